### rtl/texture_row_skip_crc32c_core_assert.svh
// Assertion macros shared by the RTL files that check their own logic.
`ifndef TEXTURE_ROW_SKIP_CRC32C_CORE_ASSERT_SVH
`define TEXTURE_ROW_SKIP_CRC32C_CORE_ASSERT_SVH

// Check on every clock edge outside reset.
`define TRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define TRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/trs_crc_pkg.sv
package trs_crc_pkg;

  // Field widths
  localparam int DIM_BITS      = 14;
  localparam int PITCH_BITS    = 20;
  localparam int DW            = DIM_BITS + 1;
  localparam int ARRAY_BITS    = 12;
  localparam int FMT_BITS      = 3;
  localparam int PIX_BITS      = 8;
  localparam int CFG_DATA_BITS = (PITCH_BITS > DW) ? PITCH_BITS : DW;
  localparam int CFG_IDX_BITS  = 3;

  // Derived geometry widths
  localparam int BLK_BITS  = DW - 1;
  localparam int RB_BITS   = DW + PIX_BITS - 2;
  localparam int RC_BITS   = DW + 1;
  localparam int ROWS_BITS = 16;
  localparam int WH_BITS   = 2 * DW;
  localparam int LEG_BITS  = 2 * DW + ARRAY_BITS;
  localparam int LEN_BITS  = ((PITCH_BITS + DW) > (2 * DW + 2)) ?
                             (PITCH_BITS + DW) : (2 * DW + 2);

  // Queue and settle timing
  localparam int QDEPTH        = 4;
  localparam int QPTR_BITS     = $clog2(QDEPTH);
  localparam int SETTLE_CYCLES = 3;
  localparam int SETTLE_BITS   = 2;

  // CRC-32C, reflected
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TEX_WIDTH    = 3'd0,
    REG_TEX_HEIGHT   = 3'd1,
    REG_ARRAY_COUNT  = 3'd2,
    REG_FORMAT_CLASS = 3'd3,
    REG_PIXEL_BITS   = 3'd4,
    REG_MEMORY_PITCH = 3'd5
  } reg_idx_t;

  typedef enum logic [FMT_BITS-1:0] {
    FMT_PLAIN   = 3'd0,
    FMT_BC8     = 3'd1,
    FMT_BC16    = 3'd2,
    FMT_PACKED4 = 3'd3,
    FMT_PACKED8 = 3'd4,
    FMT_PLANAR2 = 3'd5,
    FMT_PLANAR4 = 3'd6,
    FMT_NV11    = 3'd7
  } fmt_t;

  // Settled geometry handed from the config unit to the front end
  typedef struct packed {
    logic                  busy;
    logic                  geo_ok;
    logic [RB_BITS-1:0]    row_bytes;
    logic [RC_BITS-1:0]    row_total;
    logic [PITCH_BITS-1:0] pitch;
    logic [LEN_BITS-1:0]   start_len;
    logic                  start_legacy;
  } geo_t;

  // One classified byte in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       keep;
    logic       last_byte;
  } q_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Number of 4-wide blocks, zero for a zero dimension
  function automatic logic [BLK_BITS-1:0] blocks_of(input logic [DW-1:0] n);
    logic [DW:0] s;
    s = {1'b0, n} + (DW+1)'(3);
    return (n == '0) ? '0 : s[DW:2];
  endfunction

endpackage

### rtl/trs_crc_in_if.sv
interface trs_crc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/trs_crc_out_if.sv
interface trs_crc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

### rtl/texture_row_skip_crc32c_core.sv
// Texture row-skip CRC-32C core. Streams a texture buffer one byte per transfer and returns
// the CRC-32C (reflected, pre- and post-inverted) of the selected bytes with the final
// byte; a buffer whose bytes are all skipped hashes to 0. Sustained rate is one byte per
// clock: the front end classifies each byte combinationally and the CRC unit folds one
// byte per cycle, with a 4-entry queue between them. With the queue empty, the hash is
// registered in the output slot once the CRC unit takes the queued final byte. While a
// result waits on the output, the CRC unit keeps taking bytes up to the next final byte;
// the waiting result stalls input only once the queue is full. Each register write stalls
// input while lengths settle via the registered multiplier chain (W*H, then *array_count).
module texture_row_skip_crc32c_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  trs_crc_in_if.sink                            in_ch,
  trs_crc_out_if.source                         out_ch,
  input  logic                                  cfg_we,
  input  logic [trs_crc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [trs_crc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  trs_crc_pkg::geo_t    geo;
  logic                 push;
  trs_crc_pkg::q_item_t push_item;
  logic                 q_ready;
  logic                 pop;
  logic                 q_valid;
  trs_crc_pkg::q_item_t head;

  trs_crc_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geo       (geo)
  );

  trs_crc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .geo       (geo),
    .q_ready   (q_ready),
    .push      (push),
    .push_item (push_item)
  );

  trs_crc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  trs_crc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

### rtl/trs_crc_geom.sv
module trs_crc_geom (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [trs_crc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [trs_crc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output trs_crc_pkg::geo_t                     geo
);

  localparam int DW = trs_crc_pkg::DW;

  logic [DW-1:0]                          width_r;
  logic [DW-1:0]                          height_r;
  logic [trs_crc_pkg::ARRAY_BITS-1:0]     array_r;
  trs_crc_pkg::fmt_t                      fmt_r;
  logic [trs_crc_pkg::PIX_BITS-1:0]       pix_r;
  logic [trs_crc_pkg::PITCH_BITS-1:0]     pitch_r;
  logic [trs_crc_pkg::SETTLE_BITS-1:0]    settle_r;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(1);
      height_r <= DW'(1);
      array_r  <= trs_crc_pkg::ARRAY_BITS'(1);
      fmt_r    <= trs_crc_pkg::FMT_PLAIN;
      pix_r    <= trs_crc_pkg::PIX_BITS'(32);
      pitch_r  <= '0;
    end else if (cfg_we) begin
      unique case (trs_crc_pkg::reg_idx_t'(cfg_index))
        trs_crc_pkg::REG_TEX_WIDTH:    width_r  <= cfg_data[DW-1:0];
        trs_crc_pkg::REG_TEX_HEIGHT:   height_r <= cfg_data[DW-1:0];
        trs_crc_pkg::REG_ARRAY_COUNT:  array_r  <= cfg_data[trs_crc_pkg::ARRAY_BITS-1:0];
        trs_crc_pkg::REG_FORMAT_CLASS: fmt_r    <= trs_crc_pkg::fmt_t'(cfg_data[2:0]);
        trs_crc_pkg::REG_PIXEL_BITS:   pix_r    <= cfg_data[trs_crc_pkg::PIX_BITS-1:0];
        trs_crc_pkg::REG_MEMORY_PITCH: pitch_r  <= cfg_data[trs_crc_pkg::PITCH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Hold the front end off while the derived values run through their stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= trs_crc_pkg::SETTLE_BITS'(trs_crc_pkg::SETTLE_CYCLES);
    end else if (cfg_we) begin
      settle_r <= trs_crc_pkg::SETTLE_BITS'(trs_crc_pkg::SETTLE_CYCLES);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // Stage 1: row geometry, surface length, W*H
  logic [DW-1:0]                          w1;
  logic [DW-1:0]                          h1;
  logic [DW:0]                            w_sum1;
  logic [DW:0]                            h_sum1;
  logic [DW-1:0]                          half_w;
  logic [DW-1:0]                          half_h;
  logic [trs_crc_pkg::BLK_BITS-1:0]       blk_w;
  logic [trs_crc_pkg::BLK_BITS-1:0]       blk_h;
  logic [DW+trs_crc_pkg::PIX_BITS-1:0]    wp;
  logic [DW+trs_crc_pkg::PIX_BITS:0]      wp7;
  logic [2*trs_crc_pkg::BLK_BITS-1:0]     bwh;
  logic [trs_crc_pkg::LEN_BITS-1:0]       pitch_h;
  logic [trs_crc_pkg::RB_BITS-1:0]        rb_c;
  logic [trs_crc_pkg::RC_BITS-1:0]        rc_c;
  logic                                   ok_c;
  logic [trs_crc_pkg::LEN_BITS-1:0]       surf_c;

  logic [trs_crc_pkg::RB_BITS-1:0]        rb_r;
  logic [trs_crc_pkg::RC_BITS-1:0]        rc_r;
  logic                                   ok_r;
  logic [trs_crc_pkg::LEN_BITS-1:0]       surf_r;
  logic [trs_crc_pkg::WH_BITS-1:0]        wh_r;

  always_comb begin
    w1      = (width_r == '0) ? DW'(1) : width_r;
    h1      = (height_r == '0) ? DW'(1) : height_r;
    w_sum1  = {1'b0, width_r} + (DW+1)'(1);
    h_sum1  = {1'b0, height_r} + (DW+1)'(1);
    half_w  = w_sum1[DW:1];
    half_h  = h_sum1[DW:1];
    blk_w   = trs_crc_pkg::blocks_of(width_r);
    blk_h   = trs_crc_pkg::blocks_of(height_r);
    wp      = {trs_crc_pkg::PIX_BITS'(0), width_r} * {DW'(0), pix_r};
    wp7     = {1'b0, wp} + (DW+trs_crc_pkg::PIX_BITS+1)'(7);
    bwh     = trs_crc_pkg::blocks_of(w1) * trs_crc_pkg::blocks_of(h1);
    pitch_h = trs_crc_pkg::LEN_BITS'(pitch_r) * trs_crc_pkg::LEN_BITS'(h1);

    unique case (fmt_r)
      trs_crc_pkg::FMT_BC8: begin
        rb_c   = trs_crc_pkg::RB_BITS'({blk_w, 3'b000});
        rc_c   = trs_crc_pkg::RC_BITS'(blk_h);
        ok_c   = 1'b1;
        surf_c = trs_crc_pkg::LEN_BITS'({bwh, 3'b000});
      end
      trs_crc_pkg::FMT_BC16: begin
        rb_c   = trs_crc_pkg::RB_BITS'({blk_w, 4'b0000});
        rc_c   = trs_crc_pkg::RC_BITS'(blk_h);
        ok_c   = 1'b1;
        surf_c = trs_crc_pkg::LEN_BITS'({bwh, 4'b0000});
      end
      trs_crc_pkg::FMT_PACKED4: begin
        rb_c   = trs_crc_pkg::RB_BITS'({half_w, 2'b00});
        rc_c   = trs_crc_pkg::RC_BITS'(height_r);
        ok_c   = 1'b1;
        surf_c = pitch_h;
      end
      trs_crc_pkg::FMT_PACKED8: begin
        rb_c   = trs_crc_pkg::RB_BITS'({half_w, 3'b000});
        rc_c   = trs_crc_pkg::RC_BITS'(height_r);
        ok_c   = 1'b1;
        surf_c = pitch_h;
      end
      trs_crc_pkg::FMT_PLANAR2: begin
        rb_c   = trs_crc_pkg::RB_BITS'({half_w, 1'b0});
        rc_c   = {1'b0, height_r} + {1'b0, half_h};
        ok_c   = ~height_r[0];
        surf_c = pitch_h;
      end
      trs_crc_pkg::FMT_PLANAR4: begin
        rb_c   = trs_crc_pkg::RB_BITS'({half_w, 2'b00});
        rc_c   = {1'b0, height_r} + {1'b0, half_h};
        ok_c   = ~height_r[0];
        surf_c = pitch_h;
      end
      trs_crc_pkg::FMT_NV11: begin
        rb_c   = trs_crc_pkg::RB_BITS'({blk_w, 2'b00});
        rc_c   = {height_r, 1'b0};
        ok_c   = 1'b1;
        surf_c = pitch_h;
      end
      trs_crc_pkg::FMT_PLAIN: begin
        rb_c   = wp7[DW+trs_crc_pkg::PIX_BITS:3];
        rc_c   = trs_crc_pkg::RC_BITS'(height_r);
        ok_c   = (pix_r != '0);
        surf_c = pitch_h;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rb_r   <= rb_c;
    rc_r   <= rc_c;
    ok_r   <= ok_c;
    surf_r <= surf_c;
    wh_r   <= trs_crc_pkg::WH_BITS'(width_r) * trs_crc_pkg::WH_BITS'(height_r);
  end

  // Stage 2: legacy length W*H*array
  logic [trs_crc_pkg::LEG_BITS-1:0] leg_r;

  always_ff @(posedge clk) begin
    leg_r <= trs_crc_pkg::LEG_BITS'(wh_r) * trs_crc_pkg::LEG_BITS'(array_r);
  end

  // Stage 3: pick the mode and the length loaded at buffer start
  logic                             legacy_c;
  logic                             start_legacy_r;
  logic [trs_crc_pkg::LEN_BITS-1:0] start_len_r;

  assign legacy_c = (leg_r <= trs_crc_pkg::LEG_BITS'(surf_r));

  always_ff @(posedge clk) begin
    start_legacy_r <= legacy_c;
    start_len_r    <= legacy_c ? leg_r[trs_crc_pkg::LEN_BITS-1:0] : surf_r;
  end

  assign geo.busy         = (settle_r != '0);
  assign geo.geo_ok       = ok_r;
  assign geo.row_bytes    = rb_r;
  assign geo.row_total    = rc_r;
  assign geo.pitch        = pitch_r;
  assign geo.start_len    = start_len_r;
  assign geo.start_legacy = start_legacy_r;

endmodule

### rtl/trs_crc_front.sv
`include "texture_row_skip_crc32c_core_assert.svh"

module trs_crc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  trs_crc_in_if.sink           in_ch,
  input  trs_crc_pkg::geo_t    geo,
  input  logic                 q_ready,
  output logic                 push,
  output trs_crc_pkg::q_item_t push_item
);

  localparam int PB = trs_crc_pkg::PITCH_BITS;

  logic                              in_buf_r;
  logic                              legacy_r;
  logic [trs_crc_pkg::LEN_BITS-1:0]  left_r;
  logic [PB-1:0]                     col_r;
  logic [trs_crc_pkg::ROWS_BITS-1:0] rows_r;

  logic                              accept;
  logic                              leg_eff;
  logic [trs_crc_pkg::LEN_BITS-1:0]  left_eff;
  logic                              row_hit;
  logic                              keep;
  logic [PB:0]                       col_inc;
  logic                              row_wrap;

  assign in_ch.ready = q_ready && !geo.busy;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the byte: keep or skip
  always_comb begin
    leg_eff  = in_buf_r ? legacy_r : geo.start_legacy;
    left_eff = in_buf_r ? left_r : geo.start_len;
    row_hit  = geo.geo_ok && (geo.pitch != '0) &&
               (32'(rows_r) < 32'(geo.row_total)) &&
               (32'(col_r) < 32'(geo.row_bytes)) &&
               (col_r < geo.pitch);
    keep     = (left_eff != '0) && (leg_eff || row_hit);
    col_inc  = {1'b0, col_r} + (PB+1)'(1);
    row_wrap = (col_inc >= {1'b0, geo.pitch});
  end

  assign push                = accept;
  assign push_item.data_byte = in_ch.data_byte;
  assign push_item.keep      = keep;
  assign push_item.last_byte = in_ch.last_byte;

  // Advance the buffer position on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_buf_r <= 1'b0;
      legacy_r <= 1'b0;
      left_r   <= '0;
      col_r    <= '0;
      rows_r   <= '0;
    end else if (accept) begin
      if (in_ch.last_byte) begin
        in_buf_r <= 1'b0;
        left_r   <= '0;
        col_r    <= '0;
        rows_r   <= '0;
      end else begin
        in_buf_r <= 1'b1;
        legacy_r <= leg_eff;
        left_r   <= keep ? (left_eff - 1'b1) : left_eff;
        if (geo.pitch != '0) begin
          if (row_wrap) begin
            col_r <= '0;
            if (rows_r != '1) begin
              rows_r <= rows_r + 1'b1;
            end
          end else begin
            col_r <= col_inc[PB-1:0];
          end
        end
      end
    end
  end

  `TRS_ASSERT(a_last_ends_buffer, accept && in_ch.last_byte |=> !in_buf_r, "buffer still open after final byte")
  `TRS_ASSERT(a_byte_opens_buffer, accept && !in_ch.last_byte |=> in_buf_r, "buffer not open after a byte")
  `TRS_ASSERT(a_keep_counts_down, accept && !in_ch.last_byte && keep |=> left_r == $past(left_eff) - 1'b1, "kept byte did not count down")

endmodule

### rtl/trs_crc_queue.sv
module trs_crc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  trs_crc_pkg::q_item_t push_item,
  output logic                 q_ready,
  input  logic                 pop,
  output logic                 q_valid,
  output trs_crc_pkg::q_item_t head
);

  localparam int PW = trs_crc_pkg::QPTR_BITS;

  trs_crc_pkg::q_item_t mem_r [trs_crc_pkg::QDEPTH];
  logic [PW-1:0]        wr_ptr_r;
  logic [PW-1:0]        rd_ptr_r;
  logic [PW:0]          count_r;

  assign q_ready = (count_r != (PW+1)'(trs_crc_pkg::QDEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/trs_crc_back.sv
`include "texture_row_skip_crc32c_core_assert.svh"

module trs_crc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  trs_crc_pkg::q_item_t head,
  output logic                 pop,
  trs_crc_out_if.source        out_ch
);

  logic [31:0] crc_r;
  logic [31:0] hash_r;
  logic        out_valid_r;
  logic [31:0] crc_nxt;

  // Take a byte unless it closes a buffer while the output slot is still full
  assign pop     = q_valid && (!head.last_byte || !out_valid_r || out_ch.ready);
  assign crc_nxt = head.keep ? trs_crc_pkg::crc_byte(crc_r, head.data_byte) : crc_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = hash_r;

  // Running CRC and output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= trs_crc_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        crc_r <= head.last_byte ? trs_crc_pkg::CRC_INIT : crc_nxt;
      end
      if (pop && head.last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Finished hash, post-inverted
  always_ff @(posedge clk) begin
    if (pop && head.last_byte) begin
      hash_r <= ~crc_nxt;
    end
  end

  `TRS_ASSERT(a_last_gives_result, pop && head.last_byte |=> out_valid_r, "no result after final byte")
  `TRS_ASSERT(a_crc_restarts, pop && head.last_byte |=> crc_r == trs_crc_pkg::CRC_INIT, "crc not restarted after final byte")
  `TRS_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r, "result slot not cleared by reset")

endmodule
